[hw/rtl/dcr_pkg.sv]
package dcr_pkg;

    localparam int DEF_ENTRIES       = 16;
    localparam int DEF_PAYLOAD_BYTES = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_APPENDED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd5;

    // One stored record, kept as one memory row.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] stamp;
        logic [4:0]  len;
        logic [63:0] low;
        logic [63:0] high;
    } rec_t;

    // Mask that keeps the lowest nbytes bytes of a 64-bit word.
    function automatic logic [63:0] mask_bytes(input int nbytes);
        logic [63:0] m;
        if (nbytes >= 8)
        begin
            m = '1;
        end
        else if (nbytes <= 0)
        begin
            m = '0;
        end
        else
        begin
            m = (64'd1 << (8 * nbytes)) - 64'd1;
        end
        return m;
    endfunction

endpackage

[hw/rtl/dcr_match.sv]
module dcr_match
    import dcr_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int CNT_W  = $clog2(ENTRIES + 1)
)
(
    input  logic             clk,
    input  logic             cmp_en,
    input  logic [31:0]      cmp_key,
    input  logic [CNT_W-1:0] count,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_id,
    output logic             hit,
    output logic [IDX_W-1:0] hit_idx
);

    logic [31:0]        id_reg [ENTRIES];
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_next;

    // Every stored id is compared in parallel; slots at or beyond the count never match.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = (id_reg[i] == cmp_key) && (CNT_W'(i) < count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            match_reg <= match_next;
        end
        if (wr_en)
        begin
            id_reg[wr_idx] <= wr_id;
        end
    end

    // The lowest matching slot wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

endmodule

[hw/rtl/dedup_cache_random_replace.sv]
// Channel   Handshake                 Beat contents
// input     in_valid / in_ready       opcode, key_id, timestamp, length, data_low,
//                                     data_high, random_value, slot
// output    out_valid / out_ready     status, slot_index, found_id, found_time,
//                                     found_length, found_low, found_high, entry_count
//
// An operation runs the id compare against the id registers, then one access of
// the record memory. A replacement with ENTRIES not a power of two adds S_MOD and
// S_REM: the quotient of random_value comes from a reciprocal multiplication, then
// the remainder from one multiply and subtract. The next beat is taken in the cycle
// its predecessor moves into the output register, so a stalled output holds one
// result and one operation in flight. Reset clears the state, out_valid and the
// count; the record memory needs no clearing as no slot at or beyond it is read.
module dedup_cache_random_replace
    import dcr_pkg::*;
#(
    parameter int ENTRIES       = DEF_ENTRIES,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_id,
    input  logic [31:0] timestamp,
    input  logic [4:0]  length,
    input  logic [63:0] data_low,
    input  logic [63:0] data_high,
    input  logic [15:0] random_value,
    input  logic [3:0]  slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  slot_index,
    output logic [31:0] found_id,
    output logic [31:0] found_time,
    output logic [4:0]  found_length,
    output logic [63:0] found_low,
    output logic [63:0] found_high,
    output logic [4:0]  entry_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SLX_W = (IDX_W > 4) ? IDX_W : 4;
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int CNX_W = (CNT_W > 5) ? CNT_W : 5;
    localparam bit POW2  = (ENTRIES & (ENTRIES - 1)) == 0;

    // Rounded-up reciprocal; exact for every 16-bit dividend.
    localparam int          SHIFT = 16 + IDX_W;
    localparam logic [17:0] MAGIC = 18'(((1 << SHIFT) + ENTRIES - 1) / ENTRIES);

    localparam logic [63:0] LOW_MASK  = mask_bytes(PAYLOAD_BYTES);
    localparam logic [63:0] HIGH_MASK =
        mask_bytes((PAYLOAD_BYTES > 8) ? (PAYLOAD_BYTES - 8) : 0);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_REM    = 3'd4;

    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_MEM   = 2'd1;
    localparam logic [1:0] SRC_INPUT = 2'd2;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]  op_reg;
    logic [31:0] key_reg;
    logic [31:0] time_reg;
    logic [4:0]  len_reg;
    logic [63:0] low_reg;
    logic [63:0] high_reg;
    logic [15:0] rand_reg, rand_next;
    logic [3:0]  slot_reg;

    logic [1:0]       src_reg, src_next;
    logic [2:0]       stat_reg, stat_next;
    logic [3:0]       sidx_reg, sidx_next;
    logic [15:0]      quot_reg, quot_next;

    logic [2:0]  status_reg;
    logic [3:0]  slot_index_reg;
    rec_t        found_reg;
    logic [4:0]  entry_count_reg;

    rec_t             mem [ENTRIES];
    rec_t             rd_data_reg;
    rec_t             wr_rec;
    rec_t             emit_rec;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_idx, rd_idx;

    logic             accept;
    logic             out_free;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             full;
    logic [SLX_W-1:0] hit_x, cnt_idx_x, rand_x, rem_x;
    logic [SLX_W-1:0] slot_x;
    logic [CMP_W-1:0] slot_cmp, count_cmp;
    logic [CNX_W-1:0] count_x;
    logic [41:0]      prod;
    logic [23:0]      rem_wide;

    dcr_match #(
        .ENTRIES(ENTRIES)
    ) u_match (
        .clk     (clk),
        .cmp_en  (accept),
        .cmp_key (key_id),
        .count   (count_reg),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_id   (key_reg),
        .hit     (hit),
        .hit_idx (hit_idx)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_EMIT) && out_free);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(ENTRIES));

    assign hit_x     = SLX_W'(hit_idx);
    assign cnt_idx_x = SLX_W'(count_reg[IDX_W-1:0]);
    assign rand_x    = SLX_W'(rand_reg[IDX_W-1:0]);
    assign slot_x    = SLX_W'(slot_reg);
    assign slot_cmp  = CMP_W'(slot_reg);
    assign count_cmp = CMP_W'(count_reg);
    assign count_x   = CNX_W'(count_reg);

    // Victim slot: the quotient comes from the reciprocal product in S_MOD,
    // the remainder from one multiply and subtract in S_REM.
    assign prod     = 42'(rand_reg) * 42'(MAGIC);
    assign rem_wide = 24'(rand_reg) - 24'(quot_reg) * 24'(ENTRIES);
    assign rem_x    = SLX_W'(rem_wide[IDX_W-1:0]);

    // The record exactly as an insert stores it.
    always_comb
    begin
        wr_rec.id    = key_reg;
        wr_rec.stamp = time_reg;
        wr_rec.len   = (len_reg > 5'(PAYLOAD_BYTES)) ? 5'(PAYLOAD_BYTES) : len_reg;
        wr_rec.low   = low_reg & LOW_MASK;
        wr_rec.high  = high_reg & HIGH_MASK;
    end

    always_comb
    begin
        case (src_reg)
            SRC_MEM:   emit_rec = rd_data_reg;
            SRC_INPUT: emit_rec = wr_rec;
            default:   emit_rec = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        rand_next      = rand_reg;
        src_next       = src_reg;
        stat_next      = stat_reg;
        sidx_next      = sidx_reg;
        quot_next      = quot_reg;
        wr_en          = 1'b0;
        wr_idx         = '0;
        rd_en          = 1'b0;
        rd_idx         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_EMIT;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (hit)
                        begin
                            rd_en     = 1'b1;
                            rd_idx    = hit_idx;
                            src_next  = SRC_MEM;
                            stat_next = ST_DUPLICATE;
                            sidx_next = hit_x[3:0];
                        end
                        else if (!full)
                        begin
                            wr_en      = 1'b1;
                            wr_idx     = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                            src_next   = SRC_INPUT;
                            stat_next  = ST_APPENDED;
                            sidx_next  = cnt_idx_x[3:0];
                        end
                        else if (POW2)
                        begin
                            wr_en     = 1'b1;
                            wr_idx    = rand_reg[IDX_W-1:0];
                            src_next  = SRC_INPUT;
                            stat_next = ST_REPLACED;
                            sidx_next = rand_x[3:0];
                        end
                        else
                        begin
                            state_next = S_MOD;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit)
                        begin
                            rd_en     = 1'b1;
                            rd_idx    = hit_idx;
                            src_next  = SRC_MEM;
                            stat_next = ST_FOUND;
                            sidx_next = hit_x[3:0];
                        end
                        else
                        begin
                            src_next  = SRC_NONE;
                            stat_next = ST_NOT_FOUND;
                            sidx_next = '0;
                        end
                    end
                    OP_READ:
                    begin
                        sidx_next = slot_reg;
                        if (slot_cmp < count_cmp)
                        begin
                            rd_en     = 1'b1;
                            rd_idx    = slot_x[IDX_W-1:0];
                            src_next  = SRC_MEM;
                            stat_next = ST_FOUND;
                        end
                        else
                        begin
                            src_next  = SRC_NONE;
                            stat_next = ST_BAD_SLOT;
                        end
                    end
                    default:
                    begin
                        src_next  = SRC_NONE;
                        stat_next = ST_BAD_SLOT;
                        sidx_next = '0;
                    end
                endcase
            end
            S_MOD:
            begin
                quot_next  = prod[SHIFT +: 16];
                state_next = S_REM;
            end
            S_REM:
            begin
                wr_en      = 1'b1;
                wr_idx     = rem_wide[IDX_W-1:0];
                src_next   = SRC_INPUT;
                stat_next  = ST_REPLACED;
                sidx_next  = rem_x[3:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = accept ? S_SEARCH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            rand_next = random_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            key_reg  <= key_id;
            time_reg <= timestamp;
            len_reg  <= length;
            low_reg  <= data_low;
            high_reg <= data_high;
            slot_reg <= slot;
        end
        rand_reg <= rand_next;
        src_reg  <= src_next;
        stat_reg <= stat_next;
        sidx_reg <= sidx_next;
        quot_reg <= quot_next;

        if ((state_reg == S_EMIT) && out_free)
        begin
            status_reg      <= stat_reg;
            slot_index_reg  <= sidx_reg;
            found_reg       <= emit_rec;
            entry_count_reg <= count_x[4:0];
        end
    end

    // Record memory: one row per slot, registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot_index   = slot_index_reg;
    assign found_id     = found_reg.id;
    assign found_time   = found_reg.stamp;
    assign found_length = found_reg.len;
    assign found_low    = found_reg.low;
    assign found_high   = found_reg.high;
    assign entry_count  = entry_count_reg;

endmodule

[tb/sv/dedup_cache_random_replace_tb.sv]
module dedup_cache_random_replace_tb;
    import dcr_pkg::*;

    localparam int ENTRIES       = DEF_ENTRIES;
    localparam int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES;

    // The fourth opcode has no name in the package; the block answers it with ST_BAD_SLOT.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_OPS  = 650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;
    localparam int HOLD_AFTER  = 250;
    localparam int MAX_REPORTS = 10;
    localparam int POOL_SIZE   = 24;

    localparam logic [63:0] LOW_KEEP = (PAYLOAD_BYTES >= 8) ? '1 :
        ((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);
    localparam logic [63:0] HIGH_KEEP = (PAYLOAD_BYTES >= 16) ? '1 :
        (PAYLOAD_BYTES <= 8) ? '0 : ((64'd1 << (8 * (PAYLOAD_BYTES - 8))) - 64'd1);

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] stamp;
        logic [4:0]  len;
        logic [63:0] dlo;
        logic [63:0] dhi;
        logic [15:0] rnd;
        logic [3:0]  slot;
    } op_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_idx;
        logic [31:0] id;
        logic [31:0] stamp;
        logic [4:0]  len;
        logic [63:0] low;
        logic [63:0] high;
        logic [4:0]  count;
    } reply_t;

    typedef struct {
        op_item_t item;
        bit       typed;
        reply_t   want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] key_id;
    logic [31:0] timestamp;
    logic [4:0]  length;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [15:0] random_value;
    logic [3:0]  slot;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] found_id;
    logic [31:0] found_time;
    logic [4:0]  found_length;
    logic [63:0] found_low;
    logic [63:0] found_high;
    logic [4:0]  entry_count;

    // Shadow copy of the record store.
    rec_t       shadow_rec [ENTRIES];
    int         shadow_count;

    reply_t     pending_replies [$];
    dir_row_t   dir_rows [$];
    int         err_count;
    int         items_in;
    int         burst_left;
    logic [31:0] key_pool [POOL_SIZE];

    dedup_cache_random_replace u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .key_id       (key_id),
        .timestamp    (timestamp),
        .length       (length),
        .data_low     (data_low),
        .data_high    (data_high),
        .random_value (random_value),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_index   (slot_index),
        .found_id     (found_id),
        .found_time   (found_time),
        .found_length (found_length),
        .found_low    (found_low),
        .found_high   (found_high),
        .entry_count  (entry_count)
    );

    function automatic reply_t with_record(input reply_t r, input int idx);
        reply_t o;
        o = r;
        o.slot_idx = idx[3:0];
        o.id       = shadow_rec[idx].id;
        o.stamp    = shadow_rec[idx].stamp;
        o.len      = shadow_rec[idx].len;
        o.low      = shadow_rec[idx].low;
        o.high     = shadow_rec[idx].high;
        return o;
    endfunction

    // Works out the reply to one operation and updates the shadow store.
    function automatic reply_t lookup_outcome(input op_item_t it);
        reply_t      r;
        int          hit;
        int          idx;
        int          i;
        logic [4:0]  len_sat;
        r   = '0;
        hit = -1;
        for (i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_rec[i].id == it.key)
            begin
                hit = i;
            end
        end
        case (it.op)
            OP_INSERT:
            begin
                if (hit >= 0)
                begin
                    r.status = ST_DUPLICATE;
                    r = with_record(r, hit);
                end
                else
                begin
                    if (shadow_count < ENTRIES)
                    begin
                        idx = shadow_count;
                        shadow_count++;
                        r.status = ST_APPENDED;
                    end
                    else
                    begin
                        idx = int'(it.rnd) % ENTRIES;
                        r.status = ST_REPLACED;
                    end
                    len_sat = (it.len > 5'(PAYLOAD_BYTES)) ? 5'(PAYLOAD_BYTES) : it.len;
                    shadow_rec[idx].id    = it.key;
                    shadow_rec[idx].stamp = it.stamp;
                    shadow_rec[idx].len   = len_sat;
                    shadow_rec[idx].low   = it.dlo & LOW_KEEP;
                    shadow_rec[idx].high  = it.dhi & HIGH_KEEP;
                    r = with_record(r, idx);
                end
            end
            OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.status = ST_FOUND;
                    r = with_record(r, hit);
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_READ:
            begin
                if (int'(it.slot) < shadow_count)
                begin
                    r.status = ST_FOUND;
                    r = with_record(r, int'(it.slot));
                end
                else
                begin
                    r.status   = ST_BAD_SLOT;
                    r.slot_idx = it.slot;
                end
            end
            default:
            begin
                r.status = ST_BAD_SLOT;
            end
        endcase
        r.count = shadow_count[4:0];
        return r;
    endfunction

    function automatic op_item_t mk_item(input logic [1:0] op, input logic [31:0] key,
                                         input logic [31:0] stamp, input logic [4:0] len,
                                         input logic [63:0] dlo, input logic [63:0] dhi,
                                         input logic [15:0] rnd, input logic [3:0] slt);
        op_item_t it;
        it.op    = op;
        it.key   = key;
        it.stamp = stamp;
        it.len   = len;
        it.dlo   = dlo;
        it.dhi   = dhi;
        it.rnd   = rnd;
        it.slot  = slt;
        return it;
    endfunction

    function automatic reply_t mk_reply(input logic [2:0] st, input logic [3:0] idx,
                                        input logic [31:0] id, input logic [31:0] stamp,
                                        input logic [4:0] len, input logic [63:0] low,
                                        input logic [63:0] high, input logic [4:0] count);
        reply_t r;
        r.status   = st;
        r.slot_idx = idx;
        r.id       = id;
        r.stamp    = stamp;
        r.len      = len;
        r.low      = low;
        r.high     = high;
        r.count    = count;
        return r;
    endfunction

    task automatic add_row(input op_item_t it, input bit typed, input reply_t want);
        dir_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    function automatic op_item_t random_item();
        int          pick;
        logic [31:0] key;
        pick = $urandom_range(0, 99);
        key  = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        return mk_item((pick < 40) ? OP_INSERT : (pick < 70) ? OP_LOOKUP :
                       (pick < 95) ? OP_READ : OP_UNUSED,
                       key, $urandom,
                       ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                                   : 5'($urandom_range(0, 16)),
                       {$urandom, $urandom}, {$urandom, $urandom},
                       16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
    endfunction

    // Offers one beat, holding it until the block takes it, and records the reply
    // it should produce. Runs in bursts with random gaps in between.
    task automatic offer(input op_item_t it, input bit typed, input reply_t want);
        int     gap;
        reply_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid     <= 1'b1;
        opcode       <= it.op;
        key_id       <= it.key;
        timestamp    <= it.stamp;
        length       <= it.len;
        data_low     <= it.dlo;
        data_high    <= it.dhi;
        random_value <= it.rnd;
        slot         <= it.slot;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predicted = lookup_outcome(it);
        pending_replies.push_back(typed ? want : predicted);
        items_in++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: switches between random stall patterns, and once holds
    // off for a long stretch so that the block backs up into its input.
    initial
    begin
        int mode;
        int mode_left;
        bit held_off;
        mode      = 0;
        mode_left = 0;
        held_off  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && items_in >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) < 7);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Checks each reply beat against the oldest expected reply.
    initial
    begin
        reply_t got;
        reply_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = mk_reply(status, slot_index, found_id, found_time, found_length,
                               found_low, found_high, entry_count);
                if (pending_replies.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("unexpected reply beat: status %0d slot %0d id %h",
                                 got.status, got.slot_idx, got.id);
                    end
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.slot_idx !== want.slot_idx ||
                        got.id !== want.id || got.stamp !== want.stamp ||
                        got.len !== want.len || got.low !== want.low ||
                        got.high !== want.high || got.count !== want.count)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                        begin
                            $display("reply mismatch: expected st %0d slot %0d id %h ts %h",
                                     want.status, want.slot_idx, want.id, want.stamp);
                            $display("  len %0d lo %h hi %h count %0d",
                                     want.len, want.low, want.high, want.count);
                            $display("  actual   st %0d slot %0d id %h ts %h",
                                     got.status, got.slot_idx, got.id, got.stamp);
                            $display("  len %0d lo %h hi %h count %0d",
                                     got.len, got.low, got.high, got.count);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        opcode       = OP_INSERT;
        key_id       = '0;
        timestamp    = '0;
        length       = '0;
        data_low     = '0;
        data_high    = '0;
        random_value = '0;
        slot         = '0;
        shadow_count = 0;
        err_count    = 0;
        items_in     = 0;
        burst_left   = 0;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom;
        end

        // Empty store: misses, bad slots and the unnamed opcode.
        add_row(mk_item(OP_LOOKUP, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                mk_reply(ST_NOT_FOUND, '0, '0, '0, '0, '0, '0, '0));
        add_row(mk_item(OP_READ, '1, '0, '0, '0, '0, '1, '0), 1'b1,
                mk_reply(ST_BAD_SLOT, '0, '0, '0, '0, '0, '0, '0));
        add_row(mk_item(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1), 1'b1,
                mk_reply(ST_BAD_SLOT, '0, '0, '0, '0, '0, '0, '0));
        // Field extremes, then a duplicate that must leave the stored record alone.
        add_row(mk_item(OP_INSERT, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                mk_reply(ST_APPENDED, '0, '0, '0, '0, '0, '0, 5'd1));
        add_row(mk_item(OP_INSERT, '1, '1, 5'd16, '1, '1, '0, '0), 1'b1,
                mk_reply(ST_APPENDED, 4'd1, '1, '1, 5'd16, '1, '1, 5'd2));
        add_row(mk_item(OP_INSERT, '0, 32'h1234, 5'd5, '1, '1, '1, '0), 1'b1,
                mk_reply(ST_DUPLICATE, '0, '0, '0, '0, '0, '0, 5'd2));
        add_row(mk_item(OP_INSERT, 32'h5, $urandom, 5'd31, {$urandom, $urandom},
                        {$urandom, $urandom}, '0, '0), 1'b0, '0);
        add_row(mk_item(OP_LOOKUP, '1, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_item(OP_READ, '0, '0, '0, '0, '0, '0, 4'd2), 1'b0, '0);
        add_row(mk_item(OP_READ, '0, '0, '0, '0, '0, '0, 4'd3), 1'b1,
                mk_reply(ST_BAD_SLOT, 4'd3, '0, '0, '0, '0, '0, 5'd3));
        // Fill the store; every third of these lengths is above the limit.
        for (i = 0; i < ENTRIES - 3; i++)
        begin
            add_row(mk_item(OP_INSERT, 32'h100 + i, $urandom,
                            (i % 3 == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(0, 16)),
                            {$urandom, $urandom}, {$urandom, $urandom},
                            16'($urandom_range(0, 65535)), '0), 1'b0, '0);
        end
        // Full store: victims at both ends, then a read of the last slot.
        add_row(mk_item(OP_INSERT, 32'hABCD0000, $urandom, 5'd8, {$urandom, $urandom},
                        {$urandom, $urandom}, 16'hFFFF, '0), 1'b0, '0);
        add_row(mk_item(OP_INSERT, 32'hABCD0001, $urandom, 5'd1, {$urandom, $urandom},
                        {$urandom, $urandom}, 16'h0000, '0), 1'b0, '0);
        add_row(mk_item(OP_READ, '0, '0, '0, '0, '0, '0, 4'd15), 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end
        for (i = 0; i < RANDOM_OPS; i++)
        begin
            offer(random_item(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
